// File: src/sfa_pkg.sv
// Package: shared types, constants and codes for the sprite frame animator.
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;
    localparam int MAX_ANIMS = 16;
    localparam int IDX_W = $clog2(MAX_ANIMS);
    localparam int CNT_W = $clog2(MAX_ANIMS + 1);
    localparam int ENTRY_W = 56;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_DEFINE = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] REG_PERIOD = 3'd0;
    localparam logic [2:0] REG_WIDTH = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_PER_ROW = 3'd3;
    localparam logic [2:0] REG_NUM_FRAMES = 3'd4;
    localparam logic [2:0] REG_PAUSED = 3'd5;
    localparam logic [2:0] REG_DEFAULT_ID = 3'd6;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_SEARCH,
        t_ST_APPLY,
        t_ST_LOAD,
        t_ST_DIV_TICK,
        t_ST_DIV_FRAME,
        t_ST_DIV_LEN,
        t_ST_DIV_ROW,
        t_ST_MUL,
        t_ST_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic search_init;
        logic search_step;
        logic apply;
        logic load_cur;
        logic mul_len;
        logic div_start;
        logic [1:0] div_sel;
        logic div_done_tick;
        logic mul;
        logic emit;
    } t_cmd;

    // Status from the datapath back to the controller
    typedef struct packed {
        logic search_done;
        logic div_done;
        logic paused;
    } t_status;

    localparam logic [1:0] DIV_TICK = 2'd0;
    localparam logic [1:0] DIV_FRAME = 2'd1;
    localparam logic [1:0] DIV_LEN = 2'd2;
    localparam logic [1:0] DIV_ROW = 2'd3;
endpackage
`default_nettype wire

// File: src/sfa_divider.sv
// Restoring serial divider, one quotient bit per cycle, 24-bit operands.
`timescale 1ns / 1ps
`default_nettype none
module sfa_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [23:0] i_num,
    input  wire logic [23:0] i_den,
    output logic             o_done,
    output logic [23:0]      o_quot,
    output logic [23:0]      o_rem
);
    logic [23:0] r_quot;
    logic [24:0] r_rem;
    logic [23:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] w_shift;
    logic [24:0] w_diff;

    assign w_shift = {r_rem[23:0], r_quot[23]};
    assign w_diff = w_shift - {1'b0, r_den};

    // One shift-subtract step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[24]) begin
                r_rem <= w_diff;
                r_quot <= {r_quot[22:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quot <= {r_quot[22:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem = r_rem[23:0];
endmodule
`default_nettype wire

// File: src/sfa_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/sfa_datapath.sv
// Datapath: registers, animation table, serial divider and rectangle math.
`timescale 1ns / 1ps
`default_nettype none
module sfa_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire sfa_pkg::t_cmd            i_cmd,
    output sfa_pkg::t_status              o_status,
    input  wire logic                     i_cfg_we,
    input  wire logic [2:0]               i_cfg_addr,
    input  wire logic [31:0]              i_cfg_data,
    input  wire logic [1:0]               i_operation,
    input  wire logic [15:0]              i_delta_ms,
    input  wire logic [31:0]              i_anim_id,
    input  wire logic [11:0]              i_start_frame,
    input  wire logic [11:0]              i_end_frame,
    input  wire logic signed [15:0]       i_base_x,
    input  wire logic signed [15:0]       i_base_y,
    output logic                          o_valid,
    output logic signed [31:0]            o_left,
    output logic signed [31:0]            o_top,
    output logic signed [31:0]            o_right,
    output logic signed [31:0]            o_bottom,
    output logic [11:0]                   o_frame_index,
    output logic                          o_accepted
);
    localparam int IW = sfa_pkg::IDX_W;
    localparam int CW = sfa_pkg::CNT_W;

    // Configuration registers
    logic [9:0]  r_period;
    logic [11:0] r_fw, r_fh, r_fpr;
    logic [12:0] r_nf;
    logic        r_paused;
    logic [31:0] r_def_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 10'd33;
            r_fw <= 12'd32;
            r_fh <= 12'd32;
            r_fpr <= 12'd1;
            r_nf <= 13'd1;
            r_paused <= 1'b0;
            r_def_id <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sfa_pkg::REG_PERIOD:     r_period <= i_cfg_data[9:0];
                sfa_pkg::REG_WIDTH:      r_fw <= i_cfg_data[11:0];
                sfa_pkg::REG_HEIGHT:     r_fh <= i_cfg_data[11:0];
                sfa_pkg::REG_PER_ROW:    r_fpr <= i_cfg_data[11:0];
                sfa_pkg::REG_NUM_FRAMES: r_nf <= i_cfg_data[12:0];
                sfa_pkg::REG_PAUSED:     r_paused <= i_cfg_data[0];
                sfa_pkg::REG_DEFAULT_ID: r_def_id <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_status.paused = r_paused;

    // Effective (clamped) settings
    logic [9:0]  w_period;
    logic [12:0] w_nf;
    logic [11:0] w_fpr;
    always_comb begin
        w_period = (r_period == 10'd0) ? 10'd1 : ((r_period > 10'd1000) ? 10'd1000 : r_period);
        w_nf = (r_nf == 13'd0) ? 13'd1 : ((r_nf > 13'd4096) ? 13'd4096 : r_nf);
        w_fpr = (r_fpr == 12'd0) ? 12'd1 : r_fpr;
    end

    // Captured request
    logic [1:0]  r_op;
    logic [15:0] r_delta;
    logic [31:0] r_id;
    logic [11:0] r_sf, r_ef;
    logic [15:0] r_bx, r_by;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_operation;
            r_delta <= i_delta_ms;
            r_id <= i_anim_id;
            r_sf <= i_start_frame;
            r_ef <= i_end_frame;
            r_bx <= i_base_x;
            r_by <= i_base_y;
        end
    end

    // Table: RAM for entries 1..N-1, entry zero follows the default registers
    // unless redefined; r_e0_* hold a redefinition of entry zero.
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_cur;
    logic [22:0]   r_time;
    logic          r_e0_ovr;
    logic [11:0]   r_e0_first, r_e0_last;
    logic [IW-1:0] r_sidx;
    logic          r_found, r_sdone, r_pend;
    logic [IW-1:0] r_fidx;
    logic [sfa_pkg::ENTRY_W-1:0] w_rdata;
    logic [IW-1:0] w_raddr;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_rid;
    logic [11:0]   w_e0_last;
    logic [11:0]   r_ef_fix;
    logic          w_frames_ok;
    logic [22:0]   w_dquot_rem;

    assign w_e0_last = 12'(w_nf - 13'd1);
    assign w_rid = (r_sidx == '0) ? r_def_id : w_rdata[55:24];

    sfa_ram #(.WIDTH(sfa_pkg::ENTRY_W), .DEPTH(sfa_pkg::MAX_ANIMS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata({r_id, r_sf, r_ef_fix}), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign r_ef_fix = (r_ef < r_sf) ? r_sf : r_ef;
    assign w_frames_ok = ({1'b0, r_sf} < w_nf) && ({1'b0, r_ef} < w_nf);
    assign w_waddr = r_found ? r_fidx : r_count[IW-1:0];
    assign w_we = i_cmd.apply && (r_op == sfa_pkg::OP_DEFINE) && w_frames_ok
                  && (r_found ? (r_fidx != '0)
                              : (r_count < CW'(sfa_pkg::MAX_ANIMS)));
    assign w_raddr = (i_cmd.load_cur) ? r_cur : r_sidx;

    // Search visits one entry at a time, waiting on the registered RAM read; r_pend marks RAM data for r_sidx
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sidx <= '0;
            r_found <= 1'b0;
            r_sdone <= 1'b0;
            r_pend <= 1'b0;
            r_fidx <= '0;
        end else if (i_cmd.search_init) begin
            r_sidx <= '0;
            r_found <= 1'b0;
            r_sdone <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_cmd.search_step && !r_sdone) begin
            if (!r_pend) begin
                r_pend <= 1'b1;
            end else begin
                r_pend <= 1'b0;
                if (w_rid == r_id) begin
                    r_found <= 1'b1;
                    r_fidx <= r_sidx;
                    r_sdone <= 1'b1;
                end else if ({1'b0, r_sidx} + CW'(1) >= r_count) begin
                    r_sdone <= 1'b1;
                end else begin
                    r_sidx <= r_sidx + IW'(1);
                end
            end
        end
    end
    assign o_status.search_done = r_sdone;

    // Apply the request to state, clear entry-zero override, store tick time
    logic r_acc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            r_cur <= '0;
            r_time <= '0;
            r_e0_ovr <= 1'b0;
            r_acc <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == sfa_pkg::REG_NUM_FRAMES
                             || i_cfg_addr == sfa_pkg::REG_DEFAULT_ID)) begin
                r_e0_ovr <= 1'b0;
            end
            if (i_cmd.apply) begin
                r_acc <= 1'b0;
                case (r_op)
                    sfa_pkg::OP_TICK: r_acc <= 1'b1;
                    sfa_pkg::OP_DEFINE: begin
                        if (w_frames_ok) begin
                            if (r_found) begin
                                r_acc <= 1'b1;
                                if (r_fidx == '0) begin
                                    r_e0_ovr <= 1'b1;
                                    r_e0_first <= r_sf;
                                    r_e0_last <= r_ef_fix;
                                end
                            end else if (r_count < CW'(sfa_pkg::MAX_ANIMS)) begin
                                r_acc <= 1'b1;
                                r_count <= r_count + CW'(1);
                            end
                        end
                    end
                    sfa_pkg::OP_SELECT: begin
                        if (r_found) begin
                            r_acc <= 1'b1;
                            r_cur <= r_fidx;
                            r_time <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.div_done_tick) begin
                r_time <= w_dquot_rem;
            end
        end
    end

    // Current entry first and length
    logic [11:0] r_first;
    logic [12:0] r_len;
    logic [11:0] w_cf, w_cl;
    always_comb begin
        if (r_cur == '0) begin
            w_cf = r_e0_ovr ? r_e0_first : 12'd0;
            w_cl = r_e0_ovr ? r_e0_last : w_e0_last;
        end else begin
            w_cf = w_rdata[23:12];
            w_cl = w_rdata[11:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_len) begin
            r_first <= w_cf;
            r_len <= 13'({1'b0, w_cl} - {1'b0, w_cf} + 13'd1);
        end
    end

    // Divider sharing
    logic [23:0] w_dnum, w_dden, w_dq, w_dr, w_dquot_rem_w;
    logic [23:0] r_span, r_q;
    logic [11:0] r_frame;
    logic        w_ddone;
    assign w_dquot_rem = w_dr[22:0];
    always_comb begin
        case (i_cmd.div_sel)
            sfa_pkg::DIV_TICK:  begin w_dnum = 24'(r_time) + 24'(r_delta); w_dden = r_span; end
            sfa_pkg::DIV_FRAME: begin w_dnum = 24'(r_time); w_dden = 24'(w_period); end
            sfa_pkg::DIV_LEN:   begin w_dnum = r_q; w_dden = 24'(r_len); end
            default:            begin w_dnum = 24'(r_frame); w_dden = 24'(w_fpr); end
        endcase
    end
    assign w_dquot_rem_w = w_dq;

    sfa_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone),
        .o_quot(w_dq), .o_rem(w_dr)
    );
    assign o_status.div_done = w_ddone;

    // Span, quotient, frame and row/col bookkeeping
    logic [11:0] r_row, r_col;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_len) begin
            r_span <= 24'(w_period) * 24'({1'b0, w_cl} - {1'b0, w_cf} + 13'd1);
        end
        if (w_ddone) begin
            case (i_cmd.div_sel)
                sfa_pkg::DIV_FRAME: r_q <= w_dquot_rem_w;
                sfa_pkg::DIV_LEN:   r_frame <= 12'(r_first + w_dr[11:0]);
                sfa_pkg::DIV_ROW: begin
                    r_row <= w_dq[11:0];
                    r_col <= w_dr[11:0];
                end
                default: ;
            endcase
        end
    end

    // Rectangle products then output register
    logic [23:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_px <= 24'(r_fw) * 24'(r_col);
            r_py <= 24'(r_fh) * 24'(r_row);
        end
    end

    logic [31:0] w_left, w_top;
    assign w_left = {{16{r_bx[15]}}, r_bx} + {8'd0, r_px};
    assign w_top = {{16{r_by[15]}}, r_by} + {8'd0, r_py};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_left <= w_left;
            o_top <= w_top;
            o_right <= w_left + {20'd0, r_fw};
            o_bottom <= w_top + {20'd0, r_fh};
            o_frame_index <= r_frame;
            o_accepted <= r_acc;
        end
    end
endmodule
`default_nettype wire

// File: src/sfa_controller.sv
// Controller: sequences search, update and serial divisions per request.
`timescale 1ns / 1ps
`default_nettype none
module sfa_controller (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_operation,
    input  wire sfa_pkg::t_status i_status,
    output sfa_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);
    sfa_pkg::t_state r_state, n_state;
    logic [1:0] r_op;
    logic       r_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfa_pkg::t_ST_IDLE;
            r_op <= '0;
            r_go <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sfa_pkg::t_ST_IDLE && i_start) r_op <= i_operation;
            r_go <= (n_state != r_state);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfa_pkg::t_ST_IDLE:
                if (i_start) n_state = sfa_pkg::t_ST_SEARCH;
            sfa_pkg::t_ST_SEARCH:
                if (r_op == sfa_pkg::OP_TICK || i_status.search_done)
                    n_state = sfa_pkg::t_ST_APPLY;
            sfa_pkg::t_ST_APPLY: n_state = sfa_pkg::t_ST_LOAD;
            sfa_pkg::t_ST_LOAD:
                if (!r_go)
                    n_state = (r_op == sfa_pkg::OP_TICK && !i_status.paused)
                              ? sfa_pkg::t_ST_DIV_TICK : sfa_pkg::t_ST_DIV_FRAME;
            sfa_pkg::t_ST_DIV_TICK:
                if (i_status.div_done) n_state = sfa_pkg::t_ST_DIV_FRAME;
            sfa_pkg::t_ST_DIV_FRAME:
                if (i_status.div_done) n_state = sfa_pkg::t_ST_DIV_LEN;
            sfa_pkg::t_ST_DIV_LEN:
                if (i_status.div_done) n_state = sfa_pkg::t_ST_DIV_ROW;
            sfa_pkg::t_ST_DIV_ROW:
                if (i_status.div_done) n_state = sfa_pkg::t_ST_MUL;
            sfa_pkg::t_ST_MUL: n_state = sfa_pkg::t_ST_OUT;
            sfa_pkg::t_ST_OUT: n_state = sfa_pkg::t_ST_IDLE;
            default: n_state = sfa_pkg::t_ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != sfa_pkg::t_ST_IDLE);
        case (r_state)
            sfa_pkg::t_ST_IDLE: begin
                o_cmd.capture = i_start;
                o_cmd.search_init = i_start;
            end
            sfa_pkg::t_ST_SEARCH: o_cmd.search_step = 1'b1;
            sfa_pkg::t_ST_APPLY: o_cmd.apply = 1'b1;
            sfa_pkg::t_ST_LOAD: begin
                o_cmd.load_cur = 1'b1;
                o_cmd.mul_len = !r_go;
            end
            sfa_pkg::t_ST_DIV_TICK: begin
                o_cmd.div_sel = sfa_pkg::DIV_TICK;
                o_cmd.div_start = r_go;
                o_cmd.div_done_tick = i_status.div_done;
            end
            sfa_pkg::t_ST_DIV_FRAME: begin
                o_cmd.div_sel = sfa_pkg::DIV_FRAME;
                o_cmd.div_start = r_go;
            end
            sfa_pkg::t_ST_DIV_LEN: begin
                o_cmd.div_sel = sfa_pkg::DIV_LEN;
                o_cmd.div_start = r_go;
            end
            sfa_pkg::t_ST_DIV_ROW: begin
                o_cmd.div_sel = sfa_pkg::DIV_ROW;
                o_cmd.div_start = r_go;
            end
            sfa_pkg::t_ST_MUL: o_cmd.mul = 1'b1;
            sfa_pkg::t_ST_OUT: o_cmd.emit = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: src/sprite_frame_animator_unit.sv
// Top level: sprite-sheet frame animator, controller plus datapath.
// A request is taken at a clock edge where start is high and busy is low.
// Its result is on the outputs with o_valid for one cycle; busy drops in that
// same cycle, so the next request can be taken at the edge where the result is
// taken. Each request runs serial divisions on one shared divider: four for a
// tick, three for a paused tick. Define, select and unused codes first search
// the table one entry at a time, then run three divisions. The receiver cannot
// stall; results must be taken when o_valid is high. Configuration writes take
// effect at once and belong only where no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module sprite_frame_animator_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic [1:0]         i_operation,
    input  wire logic [15:0]        i_delta_ms,
    input  wire logic [31:0]        i_anim_id,
    input  wire logic [11:0]        i_start_frame,
    input  wire logic [11:0]        i_end_frame,
    input  wire logic signed [15:0] i_base_x,
    input  wire logic signed [15:0] i_base_y,
    output logic                    o_valid,
    output logic signed [31:0]      o_left,
    output logic signed [31:0]      o_top,
    output logic signed [31:0]      o_right,
    output logic signed [31:0]      o_bottom,
    output logic [11:0]             o_frame_index,
    output logic                    o_accepted
);
    sfa_pkg::t_cmd    w_cmd;
    sfa_pkg::t_status w_status;

    sfa_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_operation(i_operation),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(busy)
    );

    sfa_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_operation(i_operation), .i_delta_ms(i_delta_ms), .i_anim_id(i_anim_id),
        .i_start_frame(i_start_frame), .i_end_frame(i_end_frame),
        .i_base_x(i_base_x), .i_base_y(i_base_y),
        .o_valid(o_valid), .o_left(o_left), .o_top(o_top), .o_right(o_right),
        .o_bottom(o_bottom), .o_frame_index(o_frame_index), .o_accepted(o_accepted)
    );
endmodule
`default_nettype wire

// File: test/sprite_frame_animator_unit_test.sv
// Testbench: checks the sprite frame animator against a behavioral predictor.
`timescale 1ns / 1ps
`default_nettype none
module sprite_frame_animator_unit_test;
    localparam int CYCLE_LIMIT = 900000;

    logic i_clk, i_rst_n, start, busy;
    logic i_cfg_we;
    logic [2:0] i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic [1:0] i_operation;
    logic [15:0] i_delta_ms;
    logic [31:0] i_anim_id;
    logic [11:0] i_start_frame, i_end_frame;
    logic signed [15:0] i_base_x, i_base_y;
    logic o_valid;
    logic signed [31:0] o_left, o_top, o_right, o_bottom;
    logic [11:0] o_frame_index;
    logic o_accepted;

    sprite_frame_animator_unit dut (.*);

    // Expected rectangle for one request
    typedef struct {
        logic [31:0] left, top, right, bottom;
        logic [11:0] frame;
        logic acc;
    } t_rect;

    // Predictor state: registers and animation table
    logic [9:0] m_period;
    logic [11:0] m_width, m_height, m_per_row;
    logic [12:0] m_num_frames;
    logic m_paused;
    logic [31:0] m_default_id;
    logic [31:0] tbl_id[sfa_pkg::MAX_ANIMS];
    logic [11:0] tbl_first[sfa_pkg::MAX_ANIMS], tbl_last[sfa_pkg::MAX_ANIMS];
    int unsigned anim_count, cur_anim, elapsed;

    t_rect pending_rects[$];
    int errors = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    longint cycles = 0;

    function automatic int unsigned eff_period();
        if (m_period == 0) return 1;
        if (m_period > 1000) return 1000;
        return m_period;
    endfunction

    function automatic int unsigned eff_frames();
        if (m_num_frames == 0) return 1;
        if (m_num_frames > 4096) return 4096;
        return m_num_frames;
    endfunction

    function automatic int unsigned cur_idx();
        if (cur_anim >= anim_count) return 0;
        return cur_anim;
    endfunction

    function automatic int unsigned cur_len();
        int unsigned i;
        i = cur_idx();
        return (tbl_last[i] - tbl_first[i] + 1) & 32'h1FFF;
    endfunction

    function automatic int find_anim(logic [31:0] id);
        for (int i = 0; i < anim_count; i++)
            if (tbl_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void refresh_default();
        tbl_id[0] = m_default_id;
        tbl_first[0] = 0;
        tbl_last[0] = 12'(eff_frames() - 1);
    endfunction

    function automatic void model_write(logic [2:0] addr, logic [31:0] data);
        case (addr)
            sfa_pkg::REG_PERIOD: m_period = data[9:0];
            sfa_pkg::REG_WIDTH: m_width = data[11:0];
            sfa_pkg::REG_HEIGHT: m_height = data[11:0];
            sfa_pkg::REG_PER_ROW: m_per_row = data[11:0];
            sfa_pkg::REG_NUM_FRAMES: begin
                m_num_frames = data[12:0];
                refresh_default();
            end
            sfa_pkg::REG_PAUSED: m_paused = data[0];
            sfa_pkg::REG_DEFAULT_ID: begin
                m_default_id = data;
                refresh_default();
            end
            default: ;
        endcase
    endfunction

    function automatic void model_reset();
        m_period = 33; m_width = 32; m_height = 32; m_per_row = 1;
        m_num_frames = 1; m_paused = 0; m_default_id = 0;
        for (int i = 0; i < sfa_pkg::MAX_ANIMS; i++) begin
            tbl_id[i] = 0; tbl_first[i] = 0; tbl_last[i] = 0;
        end
        refresh_default();
        anim_count = 1; cur_anim = 0; elapsed = 0;
    endfunction

    function automatic t_rect predict_rect(logic [1:0] op, logic [15:0] delta,
                                           logic [31:0] id, logic [11:0] sf,
                                           logic [11:0] ef, logic [15:0] bx,
                                           logic [15:0] by);
        t_rect r;
        int unsigned per, nf, fr, pr, row, col, idx;
        int k;
        logic [11:0] ef2;
        r.acc = 0;
        per = eff_period();
        if (op == sfa_pkg::OP_TICK) begin
            if (!m_paused) elapsed = (elapsed + delta) % (per * cur_len());
            r.acc = 1;
        end else if (op == sfa_pkg::OP_DEFINE) begin
            nf = eff_frames();
            if (sf < nf && ef < nf) begin
                ef2 = (ef < sf) ? sf : ef;
                k = find_anim(id);
                if (k >= 0) begin
                    tbl_first[k] = sf; tbl_last[k] = ef2; r.acc = 1;
                end else if (anim_count < sfa_pkg::MAX_ANIMS) begin
                    tbl_id[anim_count] = id;
                    tbl_first[anim_count] = sf;
                    tbl_last[anim_count] = ef2;
                    anim_count++;
                    r.acc = 1;
                end
            end
        end else if (op == sfa_pkg::OP_SELECT) begin
            k = find_anim(id);
            if (k >= 0) begin
                cur_anim = k; elapsed = 0; r.acc = 1;
            end
        end
        idx = cur_idx();
        fr = (tbl_first[idx] + (elapsed / per) % cur_len()) & 32'hFFF;
        pr = (m_per_row == 0) ? 1 : m_per_row;
        row = fr / pr;
        col = fr % pr;
        r.left = {{16{bx[15]}}, bx} + m_width * col;
        r.top = {{16{by[15]}}, by} + m_height * row;
        r.right = r.left + m_width;
        r.bottom = r.top + m_height;
        r.frame = fr[11:0];
        return r;
    endfunction

    // Clock and cycle watchdog
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("FAILURE");
            $finish;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_rect e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_rects.size() == 0) begin
                $display("%0t: unexpected result left=%0d", $time, o_left);
                errors++;
            end else begin
                e = pending_rects.pop_front();
                if (o_left !== e.left || o_top !== e.top || o_right !== e.right ||
                    o_bottom !== e.bottom || o_frame_index !== e.frame ||
                    o_accepted !== e.acc) begin
                    $display("%0t: expected l=%0d t=%0d r=%0d b=%0d f=%0d a=%0b",
                             $time, $signed(e.left), $signed(e.top),
                             $signed(e.right), $signed(e.bottom), e.frame, e.acc);
                    $display("%0t: actual   l=%0d t=%0d r=%0d b=%0d f=%0d a=%0b",
                             $time, o_left, o_top, o_right, o_bottom,
                             o_frame_index, o_accepted);
                    errors++;
                end
            end
        end
    end

    // Write one register once nothing is in flight
    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        while (pending_rects.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_addr <= addr; i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        model_write(addr, data);
        @(posedge i_clk);
    endtask

    // Send one request, with optional idle gap first
    task automatic send_request(logic [1:0] op, logic [15:0] delta, logic [31:0] id,
                                logic [11:0] sf, logic [11:0] ef,
                                logic [15:0] bx, logic [15:0] by);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_operation <= op; i_delta_ms <= delta; i_anim_id <= id;
        i_start_frame <= sf; i_end_frame <= ef; i_base_x <= bx; i_base_y <= by;
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_rects = {pending_rects, predict_rect(op, delta, id, sf, ef, bx, by)};
        start <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_rects.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Directed: field extremes, every operation, special cases
    task automatic test_directed();
        send_request(sfa_pkg::OP_TICK, 16'hFFFF, 0, 0, 0, 16'h8000, 16'h7FFF);
        cfg_write(sfa_pkg::REG_NUM_FRAMES, 8);
        cfg_write(sfa_pkg::REG_PER_ROW, 3);
        send_request(sfa_pkg::OP_DEFINE, 0, 32'hFFFFFFFF, 2, 5, 0, 0);
        send_request(sfa_pkg::OP_DEFINE, 0, 7, 6, 1, 0, 0);        // reversed frames
        send_request(sfa_pkg::OP_DEFINE, 0, 9, 8, 2, 0, 0);        // frame out of range
        send_request(sfa_pkg::OP_DEFINE, 0, 9, 12'hFFF, 12'hFFF, 0, 0);
        send_request(sfa_pkg::OP_SELECT, 0, 32'hFFFFFFFF, 0, 0, 16'h7FFF, 16'h8000);
        send_request(sfa_pkg::OP_TICK, 100, 0, 0, 0, 0, 0);
        send_request(sfa_pkg::OP_SELECT, 0, 12345, 0, 0, 0, 0);    // unknown id
        send_request(sfa_pkg::OP_UNUSED, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        drain();
        cfg_write(sfa_pkg::REG_PAUSED, 1);
        send_request(sfa_pkg::OP_TICK, 500, 0, 0, 0, 0, 0);
        drain();
        cfg_write(sfa_pkg::REG_PAUSED, 0);
        cfg_write(sfa_pkg::REG_PERIOD, 0);                          // acts as one
        send_request(sfa_pkg::OP_TICK, 3, 0, 0, 0, 0, 0);
        drain();
        cfg_write(sfa_pkg::REG_PERIOD, 10'h3FF);                    // clamps to 1000
        cfg_write(sfa_pkg::REG_WIDTH, 0);
        cfg_write(sfa_pkg::REG_HEIGHT, 12'hFFF);
        send_request(sfa_pkg::OP_TICK, 2500, 0, 0, 0, 0, 0);
        drain();
        // fill the table to see the full-table reject
        for (int i = 0; i < sfa_pkg::MAX_ANIMS; i++)
            send_request(sfa_pkg::OP_DEFINE, 0, 100 + i, 1, 3, 0, 0);
        drain();
        cfg_write(sfa_pkg::REG_PER_ROW, 0);
        cfg_write(sfa_pkg::REG_NUM_FRAMES, 0);
        cfg_write(sfa_pkg::REG_DEFAULT_ID, 32'hFFFFFFFF);
        send_request(sfa_pkg::OP_TICK, 7, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic random_config();
        cfg_write(sfa_pkg::REG_PERIOD,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 40));
        cfg_write(sfa_pkg::REG_WIDTH, $urandom);
        cfg_write(sfa_pkg::REG_HEIGHT, $urandom);
        cfg_write(sfa_pkg::REG_PER_ROW,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 8));
        cfg_write(sfa_pkg::REG_NUM_FRAMES, ($urandom_range(7) == 0) ? $urandom :
                  (($urandom_range(3) == 0) ? 4096 : $urandom_range(1, 64)));
        cfg_write(sfa_pkg::REG_PAUSED, $urandom_range(4) == 0);
        if ($urandom_range(2) == 0) cfg_write(sfa_pkg::REG_DEFAULT_ID, $urandom_range(3));
    endtask

    // Random: mostly defines/selects over a small id pool, with ticks and unused codes
    task automatic test_random(int count, int idle_pct);
        int unsigned nf, sel;
        logic [31:0] id;
        send_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            nf = eff_frames();
            sel = $urandom_range(99);
            id = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 20);
            if (sel < 40)
                send_request(sfa_pkg::OP_TICK, ($urandom_range(5) == 0) ? $urandom :
                             $urandom_range(0, 200), $urandom, $urandom, $urandom,
                             $urandom, $urandom);
            else if (sel < 65)
                send_request(sfa_pkg::OP_DEFINE, $urandom, id,
                             ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, nf - 1),
                             ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, nf - 1),
                             $urandom, $urandom);
            else if (sel < 95)
                send_request(sfa_pkg::OP_SELECT, $urandom, id, $urandom, $urandom,
                             $urandom, $urandom);
            else
                send_request(sfa_pkg::OP_UNUSED, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
        end
        drain();
        send_idle_pct = 0;
    endtask

    initial begin
        i_rst_n = 0; start = 0; i_cfg_we = 0; i_cfg_addr = 0; i_cfg_data = 0;
        i_operation = 0; i_delta_ms = 0; i_anim_id = 0; i_start_frame = 0;
        i_end_frame = 0; i_base_x = 0; i_base_y = 0;
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        // phases: no idling, sender idle 58, no idling again, sender idle 23
        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            test_random(115, (ph % 4 == 1) ? 58 : ((ph % 4 == 3) ? 23 : 0));
        end
        $display("Covered %0d results over directed cases and 8 random config phases,",
                 results_seen);
        $display("with sender idle rates of 0, 23 and 58 percent.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
src/sfa_pkg.sv
src/sfa_divider.sv
src/sfa_ram.sv
src/sfa_datapath.sv
src/sfa_controller.sv
src/sprite_frame_animator_unit.sv
test/sprite_frame_animator_unit_test.sv
